[rtl/atrd_pkg.sv]
// ----------------------------------------------------------------------------
// atrd_pkg
// Shared types, codes and constants of the AT response detector.
// ----------------------------------------------------------------------------
package atrd_pkg;

  // Reply buffer capacity in bytes; the last slot is never filled.
  localparam int BUFFER_BYTES = 2048;
  localparam int CNT_W        = $clog2(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUFFER_BYTES - 1);

  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int TIME_W  = 32;
  localparam int OUT_W   = 3;
  localparam int BCNT_W  = 11;
  localparam int EPROG_W = 3;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // Outcome codes
  localparam logic [OUT_W-1:0] OUT_OK        = 3'd0;
  localparam logic [OUT_W-1:0] OUT_ERROR     = 3'd1;
  localparam logic [OUT_W-1:0] OUT_PROMPT    = 3'd2;
  localparam logic [OUT_W-1:0] OUT_DATA_TMO  = 3'd3;
  localparam logic [OUT_W-1:0] OUT_TOTAL_TMO = 3'd4;

  localparam logic [TIME_W-1:0] TIME_ONES = '1;

  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_O      = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_K      = 8'h4B;
  localparam logic [BYTE_W-1:0] CH_E      = 8'h45;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
  localparam logic [BYTE_W-1:0] CH_PROMPT = 8'h3E;

  localparam logic [EPROG_W-1:0] ERR_LAST = 3'd4;

  // Sticky match state carried across bytes
  typedef struct packed {
    logic [BYTE_W-1:0]  prev_byte;
    logic               crlf_seen;
    logic               ok_seen;
    logic [EPROG_W-1:0] err_prog;
    logic               err_seen;
    logic               zero_seen;
  } match_state_t;

  // Verdict of one millisecond tick
  typedef struct packed {
    logic              hit;
    logic [OUT_W-1:0]  outcome;
    logic [TIME_W-1:0] idle_nxt;
    logic [TIME_W-1:0] elapsed_nxt;
  } tick_res_t;

  // Expected character of "ERROR" at a given match position
  function automatic logic [BYTE_W-1:0] err_char(input logic [EPROG_W-1:0] pos);
    logic [BYTE_W-1:0] ch;
    unique case (pos)
      3'd0:    ch = CH_E;
      3'd1:    ch = CH_R;
      3'd2:    ch = CH_R;
      3'd3:    ch = CH_O;
      3'd4:    ch = CH_R;
      default: ch = CH_E;
    endcase
    return ch;
  endfunction

endpackage

[rtl/atrd_matcher.sv]
// ----------------------------------------------------------------------------
// atrd_matcher
// Next sticky match state for one stored reply byte.
// ----------------------------------------------------------------------------
module atrd_matcher (
  input  logic [atrd_pkg::BYTE_W-1:0] rx_byte,
  input  atrd_pkg::match_state_t      cur,
  output atrd_pkg::match_state_t      nxt
);

  logic [atrd_pkg::EPROG_W-1:0] prog_inc;

  assign prog_inc = cur.err_prog + atrd_pkg::EPROG_W'(1);

  always_comb begin
    nxt           = cur;
    nxt.prev_byte = rx_byte;
    if (!cur.zero_seen) begin
      if (rx_byte == '0) begin
        nxt.zero_seen = 1'b1;
      end else begin
        if (cur.prev_byte == atrd_pkg::CH_CR && rx_byte == atrd_pkg::CH_LF) begin
          nxt.crlf_seen = 1'b1;
        end
        if (cur.prev_byte == atrd_pkg::CH_O && rx_byte == atrd_pkg::CH_K) begin
          nxt.ok_seen = 1'b1;
        end
        // "ERROR" has no border, so a mismatch restarts at 'E' or zero
        if (rx_byte == atrd_pkg::err_char(cur.err_prog)) begin
          if (cur.err_prog == atrd_pkg::ERR_LAST) begin
            nxt.err_seen = 1'b1;
            nxt.err_prog = '0;
          end else begin
            nxt.err_prog = prog_inc;
          end
        end else begin
          nxt.err_prog = (rx_byte == atrd_pkg::CH_E) ? atrd_pkg::EPROG_W'(1) : '0;
        end
      end
    end
  end

endmodule

[rtl/atrd_tick_eval.sv]
// ----------------------------------------------------------------------------
// atrd_tick_eval
// Ordered outcome checks and timer updates for one millisecond tick.
// ----------------------------------------------------------------------------
module atrd_tick_eval (
  input  atrd_pkg::match_state_t      mst,
  input  logic                        count_nz,
  input  logic [atrd_pkg::TIME_W-1:0] idle_ticks,
  input  logic [atrd_pkg::TIME_W-1:0] elapsed_ms,
  input  logic [atrd_pkg::TIME_W-1:0] idle_limit,
  input  logic [atrd_pkg::TIME_W-1:0] total_limit,
  output atrd_pkg::tick_res_t         res
);

  logic                        idle_en;
  logic [atrd_pkg::TIME_W-1:0] idle_inc;

  assign idle_en  = (idle_limit != '0) && (idle_limit != atrd_pkg::TIME_ONES);
  assign idle_inc = (idle_ticks == atrd_pkg::TIME_ONES) ? idle_ticks
                                                        : idle_ticks + atrd_pkg::TIME_W'(1);

  always_comb begin
    res             = '0;
    res.idle_nxt    = idle_ticks;
    res.elapsed_nxt = (elapsed_ms == atrd_pkg::TIME_ONES) ? elapsed_ms
                                                          : elapsed_ms + atrd_pkg::TIME_W'(1);
    priority if (mst.crlf_seen && mst.ok_seen) begin
      res.hit     = 1'b1;
      res.outcome = atrd_pkg::OUT_OK;
    end else if (mst.crlf_seen && mst.err_seen) begin
      res.hit     = 1'b1;
      res.outcome = atrd_pkg::OUT_ERROR;
    end else if (count_nz && mst.prev_byte == atrd_pkg::CH_PROMPT) begin
      res.hit     = 1'b1;
      res.outcome = atrd_pkg::OUT_PROMPT;
    end else begin
      if (idle_en) begin
        res.idle_nxt = idle_inc;
      end
      if (idle_en && idle_inc > idle_limit) begin
        res.hit     = 1'b1;
        res.outcome = atrd_pkg::OUT_DATA_TMO;
      end else if (total_limit < res.elapsed_nxt) begin
        res.hit     = 1'b1;
        res.outcome = atrd_pkg::OUT_TOTAL_TMO;
      end
    end
  end

endmodule

[rtl/at_response_detector.sv]
// ----------------------------------------------------------------------------
// at_response_detector
// Decides the outcome of a modem command from its reply bytes and ms ticks.
// ----------------------------------------------------------------------------
// Send a start transfer (command 0) with the data and whole-command timeouts
// to arm the detector, then one transfer per reply byte (command 1) and one
// per idle millisecond (command 2). On the first tick that finds CR-LF with
// OK, CR-LF with ERROR, a trailing '>' prompt, an expired data timeout or an
// expired command timeout (checked in that order), one result transfer
// carries the outcome and the number of bytes stored; the detector then
// ignores bytes and ticks until the next start. A data timeout of zero or
// all ones disables that check. Bytes after a zero byte still count and
// reach the '>' check but no other match; bytes past BUFFER_BYTES-1 are
// dropped. Every input transfer is processed in the cycle it is accepted
// and a result appears in the output register on the next cycle, so the
// block sustains one transfer per clock. in_ready drops only while the
// output register holds a result that the sink has not taken.
// ----------------------------------------------------------------------------
module at_response_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [atrd_pkg::CMD_W-1:0]    in_command,
  input  logic [atrd_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic [atrd_pkg::TIME_W-1:0]   in_data_timeout,
  input  logic [atrd_pkg::TIME_W-1:0]   in_command_timeout,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [atrd_pkg::OUT_W-1:0]    out_outcome,
  output logic [atrd_pkg::BCNT_W-1:0]   out_byte_count
);

  // Command state
  logic                          active_r,     active_nxt;
  logic [atrd_pkg::CNT_W-1:0]    cnt_r,        cnt_nxt;
  atrd_pkg::match_state_t        mst_r,        mst_nxt;
  logic [atrd_pkg::TIME_W-1:0]   idle_r,       idle_nxt;
  logic [atrd_pkg::TIME_W-1:0]   elapsed_r,    elapsed_nxt;
  logic [atrd_pkg::TIME_W-1:0]   idle_lim_r,   idle_lim_nxt;
  logic [atrd_pkg::TIME_W-1:0]   total_lim_r,  total_lim_nxt;

  // Result register
  logic                          out_valid_r,  out_valid_nxt;
  logic [atrd_pkg::OUT_W-1:0]    outcome_r,    outcome_nxt;
  logic [atrd_pkg::BCNT_W-1:0]   bcnt_r,       bcnt_nxt;

  logic                          in_fire;
  logic                          out_fire;
  logic                          res_load;
  atrd_pkg::match_state_t        mst_byte;
  atrd_pkg::tick_res_t           tick_res;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  atrd_matcher u_matcher (
    .rx_byte (in_rx_byte),
    .cur     (mst_r),
    .nxt     (mst_byte)
  );

  atrd_tick_eval u_tick_eval (
    .mst         (mst_r),
    .count_nz    (cnt_r != '0),
    .idle_ticks  (idle_r),
    .elapsed_ms  (elapsed_r),
    .idle_limit  (idle_lim_r),
    .total_limit (total_lim_r),
    .res         (tick_res)
  );

  // A result is produced only by an accepted tick while a command runs
  assign res_load = in_fire && active_r && (in_command == atrd_pkg::CMD_TICK) && tick_res.hit;

  always_comb begin
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    mst_nxt       = mst_r;
    idle_nxt      = idle_r;
    elapsed_nxt   = elapsed_r;
    idle_lim_nxt  = idle_lim_r;
    total_lim_nxt = total_lim_r;
    if (in_fire) begin
      if (in_command == atrd_pkg::CMD_START) begin
        // Clear match state and load both timeouts
        active_nxt    = 1'b1;
        cnt_nxt       = '0;
        mst_nxt       = '0;
        idle_nxt      = '0;
        elapsed_nxt   = '0;
        idle_lim_nxt  = in_data_timeout;
        total_lim_nxt = in_command_timeout;
      end else if (active_r && in_command == atrd_pkg::CMD_BYTE) begin
        // Drop bytes once the buffer is full
        if (cnt_r < atrd_pkg::CNT_MAX) begin
          cnt_nxt  = cnt_r + atrd_pkg::CNT_W'(1);
          idle_nxt = '0;
          mst_nxt  = mst_byte;
        end
      end else if (active_r && in_command == atrd_pkg::CMD_TICK) begin
        idle_nxt    = tick_res.idle_nxt;
        elapsed_nxt = tick_res.elapsed_nxt;
        if (tick_res.hit) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    outcome_nxt   = outcome_r;
    bcnt_nxt      = bcnt_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (res_load) begin
      out_valid_nxt = 1'b1;
      outcome_nxt   = tick_res.outcome;
      bcnt_nxt      = atrd_pkg::BCNT_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cnt_r       <= '0;
      mst_r       <= '0;
      idle_r      <= '0;
      elapsed_r   <= '0;
      idle_lim_r  <= '0;
      total_lim_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      mst_r       <= mst_nxt;
      idle_r      <= idle_nxt;
      elapsed_r   <= elapsed_nxt;
      idle_lim_r  <= idle_lim_nxt;
      total_lim_r <= total_lim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result payload until it is replaced
  always_ff @(posedge clk) begin
    outcome_r <= outcome_nxt;
    bcnt_r    <= bcnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_outcome    = outcome_r;
  assign out_byte_count = bcnt_r;

`ifndef SYNTH
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_command == atrd_pkg::CMD_START) |=> (active_r && cnt_r == '0 && idle_r == '0))
    else $error("start transfer did not arm and clear the detector");

  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (!active_r && out_valid_r))
    else $error("result did not end the command");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= atrd_pkg::CNT_MAX)
    else $error("stored byte count past buffer capacity");

  a_err_prog: assert property (@(posedge clk) disable iff (!rst_n)
    mst_r.err_prog <= atrd_pkg::ERR_LAST)
    else $error("ERROR match position out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !res_load)
    else $error("result register overwritten before transfer");
`endif

endmodule
